// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the step-delay profile RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/tsdp_pkg.sv -----
// Shared types and constants of the trapezoid step-delay profile.
// Used by tsdp_front, tsdp_back and the top level; depends on nothing.
package tsdp_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_SLOW = 2'd0;
    localparam logic [1:0] CFG_FAST = 2'd1;
    localparam logic [1:0] CFG_RAMP = 2'd2;

    // Phase codes reported with each result
    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_DECEL  = 2'd1;
    localparam logic [1:0] PH_CRUISE = 2'd2;

    // Reset values of the registers
    localparam logic [15:0] SLOW_RST = 16'd2000;
    localparam logic [15:0] FAST_RST = 16'd500;
    localparam logic [15:0] RAMP_RST = 16'd200;

    // Quotient bits resolved by the divider; anything larger always saturates
    localparam int QB = 17;

    // Per-item control carried from classification to the output
    typedef struct packed {
        logic [15:0] base;      // delay the ramp term is applied to
        logic [15:0] divisor;   // ramp length, 1 when the term is zero
        logic        neg;       // ramp term is subtracted from base
        logic [1:0]  phase;
    } t_ctl;

endpackage

// ----- hw/rtl/trapezoid_step_delay_profile.sv -----
// Trapezoid step-delay profile: linear ramp delay per step of a move.
// The accepting edge loads the front register, then queue, multiply, range check, 17 divider
// stages, output register; one item per cycle while the result receiver does not stall.
// The rate is set by the restoring divider pipeline, one quotient bit per stage.
// Synchronous active-low reset clears all valid state and loads register defaults.
// Uses tsdp_pkg, tsdp_front, tsdp_queue and tsdp_back.
module trapezoid_step_delay_profile #(
    parameter int STEP_BITS = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    // input items
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [STEP_BITS-1:0] step_index, [2*STEP_BITS-1:STEP_BITS] move_length, zero pad
    input  logic [((2*STEP_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // results
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [15:0] delay_us
    output logic [15:0]          o_m_axis_tdata,
    // [1:0] phase, [2] clipped, [7:3] zero
    output logic [7:0]           o_m_axis_tuser
);
    localparam int W      = (STEP_BITS > 16) ? STEP_BITS : 16;
    localparam int D_BITS = W + 1;
    localparam int QW     = $bits(tsdp_pkg::t_ctl) + 16 + D_BITS;

    logic              f_valid, f_ready;
    tsdp_pkg::t_ctl    f_ctl, b_ctl;
    logic [15:0]       f_mag, b_mag;
    logic [D_BITS-1:0] f_dist, b_dist;
    logic              b_valid, b_ready;
    logic [QW-1:0]     q_out;
    logic [1:0]        phase;
    logic              clipped;

    assign o_cfg_ready = 1'b1;

    tsdp_front #(
        .STEP_BITS (STEP_BITS),
        .D_BITS    (D_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_step      (i_s_axis_tdata[STEP_BITS-1:0]),
        .i_len       (i_s_axis_tdata[2*STEP_BITS-1:STEP_BITS]),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_ctl       (f_ctl),
        .o_mag       (f_mag),
        .o_dist      (f_dist)
    );

    tsdp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_ctl, f_mag, f_dist}),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (q_out)
    );

    assign {b_ctl, b_mag, b_dist} = q_out;

    tsdp_back #(
        .D_BITS (D_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (b_valid),
        .o_ready   (b_ready),
        .i_ctl     (b_ctl),
        .i_mag     (b_mag),
        .i_dist    (b_dist),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_delay   (o_m_axis_tdata),
        .o_phase   (phase),
        .o_clipped (clipped)
    );

    assign o_m_axis_tuser = {5'b00000, clipped, phase};

endmodule

// ----- hw/rtl/tsdp_front.sv -----
// Front end: configuration registers, input handshake and phase classification.
// Depends on tsdp_pkg.
module tsdp_front #(
    parameter int STEP_BITS = 31,
    parameter int D_BITS    = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    // input items
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [STEP_BITS-1:0]   i_step,
    input  logic [STEP_BITS-1:0]   i_len,
    // classified items toward the queue
    output logic                   o_valid,
    input  logic                   i_ready,
    output tsdp_pkg::t_ctl         o_ctl,
    output logic [15:0]            o_mag,
    output logic [D_BITS-1:0]      o_dist
);
    `include "assert_macros.svh"

    logic [15:0] r_slow, r_fast, r_ramp;
    logic        r_valid;
    tsdp_pkg::t_ctl r_ctl;
    logic [15:0] r_mag;
    logic [D_BITS-1:0] r_dist;

    logic [D_BITS-1:0] step_e, len_e, ramp_e, sum, dist_d;
    logic [16:0]       diff;
    logic              accel, decel, dneg, zero_term;
    tsdp_pkg::t_ctl    n_ctl;
    logic [15:0]       n_mag;
    logic [D_BITS-1:0] n_dist;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow <= tsdp_pkg::SLOW_RST;
            r_fast <= tsdp_pkg::FAST_RST;
            r_ramp <= tsdp_pkg::RAMP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tsdp_pkg::CFG_SLOW: r_slow <= i_cfg_data;
                tsdp_pkg::CFG_FAST: r_fast <= i_cfg_data;
                tsdp_pkg::CFG_RAMP: r_ramp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify: accel while step < ramp, decel once step + ramp >= len
    always_comb begin
        step_e    = D_BITS'(i_step);
        len_e     = D_BITS'(i_len);
        ramp_e    = D_BITS'(r_ramp);
        sum       = step_e + ramp_e;
        dist_d    = sum - len_e;
        accel     = step_e < ramp_e;
        decel     = !accel && (sum >= len_e);
        diff      = {1'b0, r_slow} - {1'b0, r_fast};
        dneg      = diff[16];
        n_mag     = dneg ? 16'(~diff + 17'd1) : diff[15:0];
        zero_term = (r_ramp == 16'd0) || !(accel || decel);

        n_ctl.divisor = zero_term ? 16'd1 : r_ramp;
        if (accel) begin
            n_ctl.base  = r_slow;
            n_ctl.neg   = !dneg;
            n_ctl.phase = tsdp_pkg::PH_ACCEL;
            n_dist      = step_e;
        end else if (decel) begin
            n_ctl.base  = r_fast;
            n_ctl.neg   = dneg;
            n_ctl.phase = tsdp_pkg::PH_DECEL;
            n_dist      = dist_d;
        end else begin
            n_ctl.base  = r_fast;
            n_ctl.neg   = 1'b0;
            n_ctl.phase = tsdp_pkg::PH_CRUISE;
            n_dist      = '0;
        end
        if (zero_term) begin
            n_dist = '0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Output stage toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl  <= n_ctl;
            r_mag  <= n_mag;
            r_dist <= n_dist;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_mag   = r_mag;
    assign o_dist  = r_dist;

    // A held item never reports a phase outside the three codes
    `ASSERT_NEVER(a_front_phase, i_clk, i_rst_n,
        r_valid && (r_ctl.phase != tsdp_pkg::PH_ACCEL) && (r_ctl.phase != tsdp_pkg::PH_DECEL)
        && (r_ctl.phase != tsdp_pkg::PH_CRUISE), "front: bad phase code")
    // Zero divisor never reaches the back end
    `ASSERT_NEVER(a_front_div, i_clk, i_rst_n,
        r_valid && (r_ctl.divisor == 16'd0), "front: zero divisor")

endmodule

// ----- hw/rtl/tsdp_queue.sv -----
// Two-entry queue between the classifying front and the computing back.
// Depends on assert_macros.svh.
module tsdp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    `include "assert_macros.svh"

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_CLK(a_queue_cnt, i_clk, i_rst_n, r_cnt <= 2'd2, "queue: count overflow")

endmodule

// ----- hw/rtl/tsdp_back.sv -----
// Back end: ramp-term multiply, pipelined restoring divide, saturation, output register.
// Depends on tsdp_pkg.
module tsdp_back #(
    parameter int D_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // classified items from the queue
    input  logic              i_valid,
    output logic              o_ready,
    input  tsdp_pkg::t_ctl    i_ctl,
    input  logic [15:0]       i_mag,
    input  logic [D_BITS-1:0] i_dist,
    // results
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_delay,
    output logic [1:0]        o_phase,
    output logic              o_clipped
);
    `include "assert_macros.svh"

    localparam int QB     = tsdp_pkg::QB;
    localparam int N_BITS = D_BITS + 16;
    localparam int HI     = N_BITS - QB;

    logic en;

    // multiply stage
    logic                 r_m_v;
    tsdp_pkg::t_ctl       r_m_ctl;
    logic [N_BITS-1:0]    r_m_prod;

    // divider stages; index 0 is the range check
    logic [QB:0]          r_v;
    tsdp_pkg::t_ctl       r_ctl [QB+1];
    logic                 r_ovf [QB+1];
    logic [15:0]          r_rem [QB+1];
    logic [QB-1:0]        r_low [QB+1];
    logic [QB-1:0]        r_q   [QB+1];

    logic [15:0]          n_rem [QB+1];
    logic [QB-1:0]        n_low [QB+1];
    logic [QB-1:0]        n_q   [QB+1];
    logic                 n_ovf0;

    // output register
    logic                 r_o_v;
    logic [15:0]          r_o_delay;
    logic [1:0]           r_o_phase;
    logic                 r_o_clip;
    logic [15:0]          n_o_delay;
    logic                 n_o_clip;
    logic [18:0]          sum;
    logic [18:0]          qe;

    // Whole back pipeline moves together unless the result is held
    assign en      = !r_o_v || i_ready;
    assign o_ready = en;

    // Quotient of 2^QB or more saturates in either direction; then one quotient bit per stage
    always_comb begin
        logic [16:0] t;
        n_ovf0   = r_m_prod[N_BITS-1:QB] >= HI'(r_m_ctl.divisor);
        n_rem[0] = r_m_prod[QB+15:QB];
        n_low[0] = r_m_prod[QB-1:0];
        n_q[0]   = '0;
        for (int k = 1; k <= QB; k++) begin
            t = {r_rem[k-1], r_low[k-1][QB-1]};
            if (t >= {1'b0, r_ctl[k-1].divisor}) begin
                n_rem[k] = 16'(t - {1'b0, r_ctl[k-1].divisor});
                n_q[k]   = {r_q[k-1][QB-2:0], 1'b1};
            end else begin
                n_rem[k] = t[15:0];
                n_q[k]   = {r_q[k-1][QB-2:0], 1'b0};
            end
            n_low[k] = {r_low[k-1][QB-2:0], 1'b0};
        end
    end

    // Apply the term to the base and saturate
    always_comb begin
        qe  = {2'b00, r_q[QB]};
        sum = {3'b000, r_ctl[QB].base} + (r_ctl[QB].neg ? (~qe + 19'd1) : qe);
        if (r_ovf[QB]) begin
            n_o_delay = r_ctl[QB].neg ? 16'h0000 : 16'hFFFF;
            n_o_clip  = 1'b1;
        end else if (sum[18]) begin
            n_o_delay = 16'h0000;
            n_o_clip  = 1'b1;
        end else if (sum[17:16] != 2'b00) begin
            n_o_delay = 16'hFFFF;
            n_o_clip  = 1'b1;
        end else begin
            n_o_delay = sum[15:0];
            n_o_clip  = 1'b0;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_v   <= '0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r_m_v <= i_valid;
            r_v   <= {r_v[QB-1:0], r_m_v};
            r_o_v <= r_v[QB];
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_ctl  <= i_ctl;
            r_m_prod <= {{D_BITS{1'b0}}, i_mag} * {16'd0, i_dist};
            r_ctl[0] <= r_m_ctl;
            r_ovf[0] <= n_ovf0;
            r_rem[0] <= n_rem[0];
            r_low[0] <= n_low[0];
            r_q[0]   <= n_q[0];
            for (int k = 1; k <= QB; k++) begin
                r_ctl[k] <= r_ctl[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_q[k]   <= n_q[k];
            end
            r_o_delay <= n_o_delay;
            r_o_phase <= r_ctl[QB].phase;
            r_o_clip  <= n_o_clip;
        end
    end

    assign o_valid   = r_o_v;
    assign o_delay   = r_o_delay;
    assign o_phase   = r_o_phase;
    assign o_clipped = r_o_clip;

    // A clipped result sits at one of the two rails
    `ASSERT_CLK(a_back_clip, i_clk, i_rst_n,
        (r_o_v && r_o_clip) |-> ((r_o_delay == 16'h0000) || (r_o_delay == 16'hFFFF)),
        "back: clipped delay off the rails")
    // A stalled pipeline keeps its occupancy
    `ASSERT_CLK(a_back_hold, i_clk, i_rst_n,
        !en |=> ($stable(r_v) && $stable(r_m_v)), "back: pipeline moved while stalled")

endmodule

// ----- bench/tsdp_checker.sv -----
// Result checker for the trapezoid step-delay profile: watches the config, input and
// result channels, predicts each delay and compares it with the block's output.
// Depends on tsdp_pkg for register indexes, phase codes and register reset values.
module tsdp_checker #(
    parameter int STEP_W = 31,
    parameter int DATA_W = ((2*STEP_W+7)/8)*8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    // [STEP_W-1:0] step_index, [2*STEP_W-1:STEP_W] move_length
    input  logic [DATA_W-1:0] i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    // [15:0] delay_us
    input  logic [15:0]       i_out_data,
    // [1:0] phase, [2] clipped
    input  logic [7:0]        i_out_user,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] delay;
        logic [1:0]  phase;
        logic        clipped;
    } t_step_result;

    // Shadow copy of the profile registers
    logic [15:0]  slow_us;
    logic [15:0]  fast_us;
    logic [15:0]  ramp_len;
    t_step_result pending_delays[$];
    int           miss_count = 0;
    int           queue_depth = 0;
    int           result_no = 0;

    assign o_fail_count = miss_count;
    assign o_pending    = queue_depth;

    // span * offset / ramp, truncated toward zero; no ramp means no term
    function automatic longint ramp_offset(input longint span, input longint offset,
                                           input longint ramp);
        if (ramp == 0) begin
            return 0;
        end
        return (span * offset) / ramp;
    endfunction

    // Delay, phase and saturation flag for one step of a move
    function automatic t_step_result profile_delay(input logic [STEP_W-1:0] step_idx,
                                                   input logic [STEP_W-1:0] move_len);
        longint       st;
        longint       n;
        longint       r;
        longint       span;
        longint       d;
        t_step_result res;
        st   = longint'({1'b0, step_idx});
        n    = longint'({1'b0, move_len});
        r    = longint'({1'b0, ramp_len});
        span = longint'({1'b0, slow_us}) - longint'({1'b0, fast_us});
        // acceleration test wins where the ramps overlap
        if (st < r) begin
            res.phase = tsdp_pkg::PH_ACCEL;
            d = longint'({1'b0, slow_us}) - ramp_offset(span, st, r);
        end else if (st >= n - r) begin
            res.phase = tsdp_pkg::PH_DECEL;
            d = longint'({1'b0, fast_us}) + ramp_offset(span, st - (n - r), r);
        end else begin
            res.phase = tsdp_pkg::PH_CRUISE;
            d = longint'({1'b0, fast_us});
        end
        res.clipped = 1'b0;
        if (d < 0) begin
            d = 0;
            res.clipped = 1'b1;
        end else if (d > 65535) begin
            d = 65535;
            res.clipped = 1'b1;
        end
        res.delay = d[15:0];
        return res;
    endfunction

    // Track registers, queue predictions, compare results in order
    always @(posedge i_clk) begin : watch
        t_step_result got;
        t_step_result want;
        if (!i_rst_n) begin
            slow_us  = tsdp_pkg::SLOW_RST;
            fast_us  = tsdp_pkg::FAST_RST;
            ramp_len = tsdp_pkg::RAMP_RST;
            pending_delays.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tsdp_pkg::CFG_SLOW: slow_us  = i_cfg_data;
                    tsdp_pkg::CFG_FAST: fast_us  = i_cfg_data;
                    tsdp_pkg::CFG_RAMP: ramp_len = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                pending_delays.push_back(profile_delay(i_in_data[STEP_W-1:0],
                                                       i_in_data[2*STEP_W-1:STEP_W]));
            end
            if (i_out_valid && i_out_ready) begin
                got.delay   = i_out_data;
                got.phase   = i_out_user[1:0];
                got.clipped = i_out_user[2];
                result_no++;
                if (pending_delays.size() == 0) begin
                    miss_count++;
                    if (miss_count <= 10) begin
                        $display("[%0t] result %0d arrived with no item outstanding: delay %0d",
                                 $realtime, result_no, got.delay);
                    end
                end else begin
                    want = pending_delays.pop_front();
                    if (got.delay !== want.delay || got.phase !== want.phase ||
                        got.clipped !== want.clipped) begin
                        miss_count++;
                        if (miss_count <= 10) begin
                            $display({"[%0t] result %0d (exp/got): delay %0d/%0d ",
                                      "phase %0d/%0d clipped %0d/%0d"},
                                     $realtime, result_no, want.delay, got.delay,
                                     want.phase, got.phase, want.clipped, got.clipped);
                        end
                    end
                end
            end
        end
        queue_depth = pending_delays.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the step-delay profile bench: clock, reset, register writes, step items and
// result back-pressure, plus the idle watchdog and the verdict.
// Depends on tsdp_pkg, trapezoid_step_delay_profile and tsdp_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              STEP_W     = 31;
    localparam int              DATA_W     = ((2*STEP_W+7)/8)*8;
    localparam logic [30:0]     STEP_MAX   = '1;
    localparam int              IDLE_LIMIT = 2000;  // cycles with no handshake at all
    localparam int              HOLD_OFF   = 400;   // long receiver stall
    localparam int              SETTLE     = 30;    // block latency plus margin
    localparam int              RAND_SETS  = 8;
    localparam int              SET_ITEMS  = 106;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [1:0]        cfg_index = tsdp_pkg::CFG_SLOW;
    logic [15:0]       cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              m_tready = 1'b0;
    logic              cfg_ready;
    logic              s_tready;
    logic              m_tvalid;
    logic [15:0]       m_tdata;
    logic [7:0]        m_tuser;
    int                fail_count;
    int                pending;
    int                sent_count = 0;
    int                taken_count = 0;
    int                idle_cycles = 0;
    logic [15:0]       cur_ramp = tsdp_pkg::RAMP_RST;

    trapezoid_step_delay_profile #(
        .STEP_BITS(STEP_W)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    tsdp_checker #(
        .STEP_W(STEP_W)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (s_tvalid),
        .i_in_ready  (s_tready),
        .i_in_data   (s_tdata),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_data  (m_tdata),
        .i_out_user  (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 125 MHz clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if nothing moves on any channel for too long
    always @(posedge clk) begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result receiver: random stalls, zero-stall stretches, two long hold-offs
    initial begin : receiver
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken_count == 300 || taken_count == 650) begin
                stall = HOLD_OFF;
            end else if (taken_count % 128 < 40) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 3);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            taken_count++;
        end
    end

    function automatic logic [30:0] rand_step();
        logic [31:0] w;
        w = $urandom();
        return w[30:0];
    endfunction

    function automatic logic [30:0] to_step(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > STEP_MAX) begin
            return STEP_MAX;
        end
        return v[30:0];
    endfunction

    // Offer one step item after a random gap and wait for its acceptance
    task automatic send_step(input logic [30:0] step_idx, input logic [30:0] move_len);
        int gap;
        gap = (sent_count % 128 < 40) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W-2*STEP_W){1'b0}}, move_len, step_idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
    endtask

    // Stop offering, let every outstanding result come back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        // let the checker count the last accepted item before the pending check
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Load a full profile; only called with the block idle
    task automatic write_profile(input logic [15:0] slow, input logic [15:0] fast,
                                 input logic [15:0] ramp);
        cfg_write(tsdp_pkg::CFG_SLOW, slow);
        cfg_write(tsdp_pkg::CFG_FAST, fast);
        cfg_write(tsdp_pkg::CFG_RAMP, ramp);
        cfg_valid <= 1'b0;
        cur_ramp = ramp;
    endtask

    function automatic logic [15:0] pick_delay();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 4000));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_ramp();
        case ($urandom_range(0, 5))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(1, 300));
            4:       return 16'($urandom_range(1, 4000));
            default: return 16'($urandom());
        endcase
    endfunction

    // Mostly whole moves around the ramps, some boundary hits, some raw noise
    task automatic send_random();
        longint r;
        longint n;
        longint st;
        int     kind;
        r    = longint'({1'b0, cur_ramp});
        kind = $urandom_range(0, 19);
        n    = $urandom_range(0, 4 * r + 20);
        if (kind < 12) begin
            st = $urandom_range(0, n + r / 2 + 2);
        end else if (kind < 15) begin
            case ($urandom_range(0, 6))
                0:       st = r - 1;
                1:       st = r;
                2:       st = n - r - 1;
                3:       st = n - r;
                4:       st = n - 1;
                5:       st = n;
                default: st = n + 1;
            endcase
        end else if (kind < 18) begin
            n  = rand_step();
            st = rand_step();
        end else begin
            n = rand_step();
            if ($urandom_range(0, 1) == 1) begin
                st = $urandom_range(0, r);
            end else begin
                st = n - $urandom_range(0, r) + $urandom_range(0, 3);
            end
        end
        send_step(to_step(st), to_step(n));
    endtask

    // Main sequence
    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset profile: each phase, its edges, short move, steps past the end
        send_step(31'd0, 31'd1000);
        send_step(31'd199, 31'd1000);
        send_step(31'd200, 31'd1000);
        send_step(31'd799, 31'd1000);
        send_step(31'd800, 31'd1000);
        send_step(31'd999, 31'd1000);
        send_step(31'd1000, 31'd1000);
        send_step(STEP_MAX, 31'd1000);
        send_step(31'd0, 31'd0);
        send_step(31'd100, 31'd300);
        send_step(31'd250, 31'd300);
        send_step(STEP_MAX, STEP_MAX);
        send_step(31'd1000, STEP_MAX);
        drain();

        // fast delay above slow: negative slope, clamps at zero past the end
        write_profile(16'd100, 16'd60000, 16'd1000);
        send_step(31'd500, 31'd5000);
        send_step(31'd4500, 31'd5000);
        send_step(STEP_MAX, 31'd5000);
        drain();

        // zero ramp: cruise before the end, decelerating at or past it
        write_profile(16'hFFFF, 16'd0, 16'd0);
        send_step(31'd5, 31'd10);
        send_step(31'd10, 31'd10);
        send_step(31'd0, 31'd0);
        drain();

        // longest ramp, saturation high
        write_profile(16'hFFFF, 16'd0, 16'hFFFF);
        send_step(STEP_MAX, 31'd100);
        send_step(31'd65534, STEP_MAX);
        drain();

        // all-zero delays, single-step ramp
        write_profile(16'd0, 16'd0, 16'd1);
        send_step(31'd0, 31'd5);
        send_step(31'd3, 31'd5);
        send_step(31'd4, 31'd5);
        drain();

        // random profiles with random moves
        for (int set_no = 0; set_no < RAND_SETS; set_no++) begin
            write_profile(pick_delay(), pick_delay(), pick_ramp());
            for (int k = 0; k < SET_ITEMS; k++) begin
                send_random();
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/tsdp_pkg.sv
hw/rtl/tsdp_front.sv
hw/rtl/tsdp_queue.sv
hw/rtl/tsdp_back.sv
hw/rtl/trapezoid_step_delay_profile.sv
bench/tsdp_checker.sv
bench/tb_top.sv
